/* src/esc_dec_pkg.sv */
// package for the backslash escape decoder
// holds the character codes, mode codes, limits and the state and result types
package esc_dec_pkg;

    localparam int unsigned MAX_CHARS = 255;

    localparam logic [1:0] MODE_PLAIN  = 2'd0;
    localparam logic [1:0] MODE_ESC    = 2'd1;
    localparam logic [1:0] MODE_DIGITS = 2'd2;
    localparam logic [1:0] MODE_CARET  = 2'd3;

    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_CARET  = 8'h5e;
    localparam logic [7:0] CH_QMARK  = 8'h3f;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_R      = 8'h72;

    localparam logic [7:0] CODE_BS  = 8'o010;
    localparam logic [7:0] CODE_HT  = 8'o011;
    localparam logic [7:0] CODE_LF  = 8'o012;
    localparam logic [7:0] CODE_FF  = 8'o014;
    localparam logic [7:0] CODE_CR  = 8'o015;
    localparam logic [7:0] CODE_DEL = 8'o177;
    localparam logic [7:0] CTRL_MASK = 8'o037;

    localparam logic [7:0] MAX_COUNT = 8'd255;
    localparam logic [7:0] CHAR_LIMIT = 8'(MAX_CHARS);

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] digit_count;
        logic [7:0] digit_value;
        logic [7:0] chars_seen;
        logic [7:0] bytes_made;
    } t_state;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       byte_valid;
        logic       done_res;
        logic [7:0] out_length;
    } t_res;

    typedef struct packed {
        logic have0;
        logic have1;
        t_res res0;
        t_res res1;
    } t_emit;

endpackage

/* src/backslash_escape_decoder_top.sv */
// top level of the backslash escape decoder
// holds the decode state and joins esc_dec_step and esc_dec_queue, depends on esc_dec_pkg
//
// Decodes backslash escapes in a character stream, one character item per clock while
// o_in_ready is high. An accepted item updates the decode state in the same cycle and
// its results (none, one or two) are registered into a four-entry result queue and
// offered from its head. The queue drains one result per cycle while i_out_ready is
// high, so items that give at most one result stream at one per cycle; items that give
// two (a digit escape cut short by a plain character, or an end item with a pending
// escape) fill two queue entries, and o_in_ready drops while fewer than two are free.
module backslash_escape_decoder_top import esc_dec_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_end_mark,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_byte_out,
    output logic       o_byte_valid,
    output logic       o_done_res,
    output logic [7:0] o_out_length
);

    t_state r_state;
    t_state n_state;
    t_emit  emit;
    t_res   head;
    logic   accept;
    logic   room2;

    assign o_in_ready = room2;
    assign accept     = i_in_valid && room2;

    esc_dec_step u_step (
        .i_state    (r_state),
        .i_char_in  (i_char_in),
        .i_end_mark (i_end_mark),
        .o_state    (n_state),
        .o_emit     (emit)
    );

    esc_dec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .i_push  (accept),
        .o_room2 (room2),
        .o_head  (head),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    assign o_byte_out   = head.byte_out;
    assign o_byte_valid = head.byte_valid;
    assign o_done_res   = head.done_res;
    assign o_out_length = head.out_length;

    // end item clears the string state
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_end_mark |=> r_state.mode == MODE_PLAIN && r_state.chars_seen == 8'd0
            && r_state.bytes_made == 8'd0)
        else $error("string state not cleared after end item");

    // digit count only nonzero inside a digit escape
    a_digit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == MODE_DIGITS) == (r_state.digit_count == 2'd1
            || r_state.digit_count == 2'd2))
        else $error("digit count out of step with mode");

    // characters past the limit leave the state alone
    a_over_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_end_mark && r_state.chars_seen >= CHAR_LIMIT |=> $stable(r_state))
        else $error("state changed by character past the limit");

    // an end item always leaves a done result behind
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_end_mark |-> (emit.have1 && emit.res1.done_res)
            || (emit.have0 && !emit.have1 && emit.res0.done_res))
        else $error("end item without done result");

endmodule

/* src/esc_dec_step.sv */
// per-item decode logic of the backslash escape decoder
// maps the current state and one input item to the next state and up to two results
// depends on esc_dec_pkg
module esc_dec_step import esc_dec_pkg::*; (
    input  t_state     i_state,
    input  logic [7:0] i_char_in,
    input  logic       i_end_mark,
    output t_state     o_state,
    output t_emit      o_emit
);

    logic       is_digit;
    logic [7:0] digit;
    logic [7:0] acc_value;
    logic       v0;
    logic       v1;
    logic       bv0;
    logic       bv1;
    logic       dn1;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] len0;
    logic [7:0] len1;

    assign is_digit  = (i_char_in >= CH_ZERO) && (i_char_in <= CH_NINE);
    assign digit     = i_char_in - CH_ZERO;
    assign acc_value = {i_state.digit_value[4:0], 3'b000} + {4'b0000, digit[3:0]};

    always_comb begin
        o_state = i_state;
        v0  = 1'b0;
        v1  = 1'b0;
        bv0 = 1'b1;
        bv1 = 1'b1;
        dn1 = 1'b0;
        b0  = 8'd0;
        b1  = 8'd0;
        if (i_end_mark) begin
            unique case (i_state.mode)
                MODE_DIGITS: begin
                    v0 = 1'b1;
                    b0 = i_state.digit_value;
                    v1 = 1'b1;
                    bv1 = 1'b0;
                    dn1 = 1'b1;
                end
                MODE_ESC, MODE_CARET: begin
                    v0 = 1'b1;
                    v1 = 1'b1;
                    bv1 = 1'b0;
                    dn1 = 1'b1;
                end
                default: begin
                    v1 = 1'b1;
                    bv1 = 1'b0;
                    dn1 = 1'b1;
                end
            endcase
        end else if (i_state.chars_seen < CHAR_LIMIT) begin
            o_state.chars_seen = i_state.chars_seen + 8'd1;
            unique case (i_state.mode)
                MODE_PLAIN: begin
                    if (i_char_in == CH_BSLASH) begin
                        o_state.mode = MODE_ESC;
                    end else begin
                        v0 = 1'b1;
                        b0 = i_char_in;
                    end
                end
                MODE_ESC: begin
                    if (is_digit) begin
                        o_state.digit_value = digit;
                        o_state.digit_count = 2'd1;
                        o_state.mode = MODE_DIGITS;
                    end else begin
                        o_state.mode = MODE_PLAIN;
                        v0 = 1'b1;
                        case (i_char_in)
                            CH_B:     b0 = CODE_BS;
                            CH_T:     b0 = CODE_HT;
                            CH_N:     b0 = CODE_LF;
                            CH_F:     b0 = CODE_FF;
                            CH_R:     b0 = CODE_CR;
                            CH_CARET: begin
                                v0 = 1'b0;
                                o_state.mode = MODE_CARET;
                            end
                            default:  b0 = i_char_in;
                        endcase
                    end
                end
                MODE_DIGITS: begin
                    if (is_digit) begin
                        if (i_state.digit_count >= 2'd2) begin
                            v0 = 1'b1;
                            b0 = acc_value;
                            o_state.mode = MODE_PLAIN;
                            o_state.digit_count = 2'd0;
                            o_state.digit_value = 8'd0;
                        end else begin
                            o_state.digit_value = acc_value;
                            o_state.digit_count = i_state.digit_count + 2'd1;
                        end
                    end else begin
                        v0 = 1'b1;
                        b0 = i_state.digit_value;
                        o_state.digit_count = 2'd0;
                        o_state.digit_value = 8'd0;
                        if (i_char_in == CH_BSLASH) begin
                            o_state.mode = MODE_ESC;
                        end else begin
                            o_state.mode = MODE_PLAIN;
                            v1 = 1'b1;
                            b1 = i_char_in;
                        end
                    end
                end
                default: begin
                    o_state.mode = MODE_PLAIN;
                    v0 = 1'b1;
                    b0 = (i_char_in == CH_QMARK) ? CODE_DEL : (i_char_in & CTRL_MASK);
                end
            endcase
        end
        // pack a lone second result into the first slot
        if (!v0 && v1) begin
            v0  = 1'b1;
            bv0 = bv1;
            b0  = b1;
            v1  = 1'b0;
        end
        len0 = i_state.bytes_made
             + {7'd0, v0 && bv0 && (i_state.bytes_made != MAX_COUNT)};
        len1 = len0 + {7'd0, v1 && bv1 && (len0 != MAX_COUNT)};
        o_state.bytes_made = len1;
        if (i_end_mark) begin
            o_state = '0;
        end
    end

    assign o_emit.have0           = v0;
    assign o_emit.have1           = v1;
    assign o_emit.res0.byte_out   = b0;
    assign o_emit.res0.byte_valid = bv0;
    assign o_emit.res0.done_res   = i_end_mark && !v1;
    assign o_emit.res0.out_length = len0;
    assign o_emit.res1.byte_out   = b1;
    assign o_emit.res1.byte_valid = bv1;
    assign o_emit.res1.done_res   = dn1;
    assign o_emit.res1.out_length = len1;

endmodule

/* src/esc_dec_queue.sv */
// small result queue of the backslash escape decoder, depends on esc_dec_pkg
// takes up to two results per cycle and hands out one per cycle while i_ready is high
module esc_dec_queue import esc_dec_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_emit i_emit,
    input  logic  i_push,
    output logic  o_room2,
    output t_res  o_head,
    output logic  o_valid,
    input  logic  i_ready
);

    t_res              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;
    logic [QPTR_W-1:0] wr_ptr1;
    logic              w0;
    logic              w1;
    logic              pop;

    assign w0      = i_push && i_emit.have0;
    assign w1      = i_push && i_emit.have1;
    assign pop     = o_valid && i_ready;
    assign wr_ptr1 = r_wr_ptr + QPTR_W'(1);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_room2 = (r_count <= QCNT_W'(QUEUE_DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr + QPTR_W'(w0) + QPTR_W'(w1);
        n_rd_ptr = r_rd_ptr + QPTR_W'(pop);
        n_count  = r_count + QCNT_W'(w0) + QCNT_W'(w1) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w0) begin
            r_mem[r_wr_ptr] <= i_emit.res0;
        end
        if (w1) begin
            r_mem[wr_ptr1] <= i_emit.res1;
        end
    end

endmodule

/* test/backslash_escape_decoder_top_tb.sv */
`timescale 1ns / 1ps
// testbench for backslash_escape_decoder_top, uses esc_dec_pkg for codes and the result type
// an in-file decode predictor feeds a queue of expected results; each output item is checked

module backslash_escape_decoder_top_tb;
    import esc_dec_pkg::*;

    localparam int unsigned ITEM_TARGET = 1000;
    localparam int unsigned CALM_ITEMS = 150;
    localparam int unsigned HOLD_CYCLES = 100;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned WATCH_LIMIT = 2000;
    localparam logic [7:0] ESC_LETTERS [5] = '{CH_B, CH_T, CH_N, CH_F, CH_R};

    class esc_scoreboard;
        logic [1:0] mode;
        logic [1:0] digit_count;
        logic [7:0] digit_value;
        logic [7:0] chars_seen;
        logic [7:0] bytes_made;
        t_res decoded_q[$];
        int unsigned errors;
        int unsigned checked;

        function new();
            clear();
            errors = 0;
            checked = 0;
        endfunction

        function void clear();
            mode = MODE_PLAIN;
            digit_count = 2'd0;
            digit_value = 8'd0;
            chars_seen = 8'd0;
            bytes_made = 8'd0;
        endfunction

        function void emit(logic [7:0] b, logic v, logic d);
            t_res r;
            if (v && bytes_made < MAX_COUNT) begin
                bytes_made++;
            end
            r.byte_out = b;
            r.byte_valid = v;
            r.done_res = d;
            r.out_length = bytes_made;
            decoded_q.push_back(r);
        endfunction

        function void take_plain(logic [7:0] c);
            if (c == CH_BSLASH) begin
                mode = MODE_ESC;
            end else begin
                emit(c, 1'b1, 1'b0);
            end
        endfunction

        function void note_item(logic [7:0] c, logic e);
            logic is_num;
            is_num = (c >= CH_ZERO) && (c <= CH_NINE);
            if (e) begin
                if (mode == MODE_DIGITS) begin
                    emit(digit_value, 1'b1, 1'b0);
                end else if (mode != MODE_PLAIN) begin
                    emit(8'd0, 1'b1, 1'b0);
                end
                emit(8'd0, 1'b0, 1'b1);
                clear();
                return;
            end
            if (chars_seen >= CHAR_LIMIT) begin
                return;
            end
            chars_seen++;
            case (mode)
                MODE_PLAIN: take_plain(c);
                MODE_ESC: begin
                    if (is_num) begin
                        digit_value = c - CH_ZERO;
                        digit_count = 2'd1;
                        mode = MODE_DIGITS;
                    end else begin
                        mode = MODE_PLAIN;
                        case (c)
                            CH_B: emit(CODE_BS, 1'b1, 1'b0);
                            CH_T: emit(CODE_HT, 1'b1, 1'b0);
                            CH_N: emit(CODE_LF, 1'b1, 1'b0);
                            CH_F: emit(CODE_FF, 1'b1, 1'b0);
                            CH_R: emit(CODE_CR, 1'b1, 1'b0);
                            CH_CARET: mode = MODE_CARET;
                            default: emit(c, 1'b1, 1'b0);
                        endcase
                    end
                end
                MODE_DIGITS: begin
                    if (is_num) begin
                        digit_value = (digit_value << 3) + (c - CH_ZERO);
                        digit_count++;
                        if (digit_count == 2'd3) begin
                            emit(digit_value, 1'b1, 1'b0);
                            mode = MODE_PLAIN;
                            digit_count = 2'd0;
                            digit_value = 8'd0;
                        end
                    end else begin
                        emit(digit_value, 1'b1, 1'b0);
                        mode = MODE_PLAIN;
                        digit_count = 2'd0;
                        digit_value = 8'd0;
                        take_plain(c);
                    end
                end
                default: begin
                    mode = MODE_PLAIN;
                    emit((c == CH_QMARK) ? CODE_DEL : (c & CTRL_MASK), 1'b1, 1'b0);
                end
            endcase
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (decoded_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected item: byte %0h valid %0b done %0b length %0d",
                         $time, got.byte_out, got.byte_valid, got.done_res, got.out_length);
                return;
            end
            want = decoded_q.pop_front();
            checked++;
            if (got.byte_out !== want.byte_out) begin
                errors++;
                $display("%0t: byte_out expected %0h actual %0h",
                         $time, want.byte_out, got.byte_out);
            end
            if (got.byte_valid !== want.byte_valid) begin
                errors++;
                $display("%0t: byte_valid expected %0b actual %0b",
                         $time, want.byte_valid, got.byte_valid);
            end
            if (got.done_res !== want.done_res) begin
                errors++;
                $display("%0t: done_res expected %0b actual %0b",
                         $time, want.done_res, got.done_res);
            end
            if (got.out_length !== want.out_length) begin
                errors++;
                $display("%0t: out_length expected %0d actual %0d",
                         $time, want.out_length, got.out_length);
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_char_in = 8'd0;
    logic       i_end_mark = 1'b0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_byte_out;
    logic       o_byte_valid;
    logic       o_done_res;
    logic [7:0] o_out_length;

    esc_scoreboard sb = new();
    int unsigned items_sent = 0;
    int unsigned strings_done = 0;
    int unsigned long_holds = 0;
    int unsigned idle_cycles = 0;
    bit in_idle_on = 1'b0;
    bit out_idle_on = 1'b0;
    bit hold_req = 1'b0;

    backslash_escape_decoder_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_char_in    (i_char_in),
        .i_end_mark   (i_end_mark),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_byte_out   (o_byte_out),
        .o_byte_valid (o_byte_valid),
        .o_done_res   (o_done_res),
        .o_out_length (o_out_length)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            sb.note_item(i_char_in, i_end_mark);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result('{o_byte_out, o_byte_valid, o_done_res, o_out_length});
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCH_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, WATCH_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] c, input logic e);
        i_in_valid <= 1'b1;
        i_char_in <= c;
        i_end_mark <= e;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (e) begin
            strings_done++;
        end
        if (in_idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            i_char_in <= 8'($urandom_range(0, 255));
            i_end_mark <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_item(s[k], 1'b0);
        end
    endtask

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    task automatic send_token();
        int unsigned kind;
        logic [7:0] c;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2: send_item(8'($urandom_range(0, 255)), 1'b0);
            3: begin
                send_item(CH_BSLASH, 1'b0);
                send_item(ESC_LETTERS[3'($urandom_range(0, 4))], 1'b0);
            end
            4: begin
                send_item(CH_BSLASH, 1'b0);
                repeat ($urandom_range(1, 3)) send_item(rand_digit(), 1'b0);
            end
            5: begin
                c = ($urandom_range(0, 3) == 0) ? CH_QMARK : 8'($urandom_range(0, 255));
                send_item(CH_BSLASH, 1'b0);
                send_item(CH_CARET, 1'b0);
                send_item(c, 1'b0);
            end
            6: begin
                send_item(CH_BSLASH, 1'b0);
                send_item(8'($urandom_range(0, 255)), 1'b0);
            end
            7: begin
                c = 8'($urandom_range(0, 255));
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    c = c ^ 8'h40;
                end
                send_item(CH_BSLASH, 1'b0);
                repeat ($urandom_range(1, 2)) send_item(rand_digit(), 1'b0);
                send_item(c, 1'b0);
            end
            default: send_item(CH_BSLASH, 1'b0);
        endcase
    endtask

    initial begin
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                long_holds++;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (out_idle_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        bit long_done;
        bit held;
        int unsigned n;
        long_done = 1'b0;
        held = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed strings: field extremes, each escape form, endings with a pending escape
        send_item(8'h00, 1'b0);
        send_item(CH_BSLASH, 1'b0);
        send_item(8'hff, 1'b0);
        send_text("\\n\\9x\\777\\^?\\1");
        send_item(8'hff, 1'b1);
        send_text("\\b\\t\\f\\r\\");
        send_item(8'h00, 1'b1);
        send_text("\\^");
        send_item(8'h5a, 1'b1);

        while (items_sent < ITEM_TARGET) begin
            if (items_sent + CALM_ITEMS >= ITEM_TARGET) begin
                in_idle_on = 1'b0;
                out_idle_on = 1'b0;
            end else begin
                in_idle_on = ($urandom_range(0, 2) != 0);
                out_idle_on = ($urandom_range(0, 2) != 0);
            end
            if (!held && items_sent >= 400) begin
                held = 1'b1;
                hold_req = 1'b1;
            end
            if (!long_done) begin
                long_done = 1'b1;
                repeat ($urandom_range(260, 290)) send_item(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
                repeat (n) send_token();
            end
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end
        i_in_valid <= 1'b0;

        while (sb.decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d input items over %0d strings, %0d output items checked",
                 items_sent, strings_done, sb.checked);
        $display("output held off at length %0d time(s), with random idling on both sides",
                 long_holds);
        if (sb.errors == 0 && sb.decoded_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
src/esc_dec_pkg.sv
src/esc_dec_step.sv
src/esc_dec_queue.sv
src/backslash_escape_decoder_top.sv
test/backslash_escape_decoder_top_tb.sv
